/* sv/dcfw_pkg.sv */
package dcfw_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned CMD_W = 2;
   localparam int unsigned RADDR_W = 10;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned PAINT_ROWS = 8;
   localparam int unsigned ROW_CNT_W = $clog2(PAINT_ROWS);

   localparam logic [CMD_W-1:0] CMD_STREAM = 2'd0;
   localparam logic [CMD_W-1:0] CMD_START = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_PANEL_WIDTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_OPCODE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE_OPCODE = 2'd2;

   localparam logic [BYTE_W-1:0] AWAIT_MODE = 8'hFF;
   localparam logic [BYTE_W-1:0] DATA_MODE = 8'h40;
   localparam logic [BYTE_W-1:0] COMMAND_MODE = 8'h00;
   localparam logic [BYTE_W-1:0] RESET_DISPLAY_MODE = 8'h01;
   localparam logic [BYTE_W-1:0] RESET_PANEL_WIDTH = 8'd128;
   localparam logic [BYTE_W-1:0] RESET_BLOCK_OPCODE = 8'd1;
   localparam logic [BYTE_W-1:0] RESET_MODE_OPCODE = 8'd2;

   typedef struct packed {
      logic clear_wr;
      logic accept;
      logic paint_rd;
      logic paint_wr;
      logic load_rsp;
   } dcfw_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic paint_req;
   } dcfw_status_type;

endpackage

/* sv/dcfw_req_if.sv */
interface dcfw_req_if;
   logic                              valid;
   logic                              ready;
   logic [dcfw_pkg::CMD_W-1:0]        command;
   logic [dcfw_pkg::BYTE_W-1:0]       byte_value;
   logic [dcfw_pkg::RADDR_W-1:0]      read_address;

   modport source (output valid, command, byte_value, read_address, input ready);
   modport sink (input valid, command, byte_value, read_address, output ready);
endinterface

/* sv/dcfw_rsp_if.sv */
interface dcfw_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [dcfw_pkg::BYTE_W-1:0]       read_data;
   logic [dcfw_pkg::BYTE_W-1:0]       display_mode;

   modport source (output valid, read_data, display_mode, input ready);
   modport sink (input valid, read_data, display_mode, output ready);
endinterface

/* sv/display_command_framebuffer_writer_unit.sv */
// Display command writer: parses a controller byte stream and paints a one-bit frame store.
// Requests arrive on req_chan (command, byte_value, read_address) and every request
// produces exactly one response on rsp_chan (read_data, display_mode).
// A start request returns the parser to awaiting a mode byte; a stream byte is parsed
// as mode, command, argument or eight vertical pixels; a read request returns a store byte.
// Settings should be written through the csr_ port only while no request is in flight;
// the block does not enforce this. A non-pixel request waits after acceptance only for
// the response register to free before its response is loaded. A pixel byte first has
// each of its eight store bytes read and then written back, one after the other.
// After reset the store is swept to zero, one byte per cycle, across all
// ROW_BYTES * PIXEL_ROWS bytes (1024 by default); no request is taken meanwhile.
// The response register holds a finished response until rsp_chan.ready is seen; a
// further request may be accepted meanwhile and waits for the register to free.
module display_command_framebuffer_writer_unit #(
   parameter int unsigned ROW_BYTES = 16,
   parameter int unsigned PIXEL_ROWS = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   dcfw_req_if.sink                        req_chan,
   dcfw_rsp_if.source                      rsp_chan,
   input  logic                            csr_write_enable,
   input  logic [dcfw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dcfw_pkg::BYTE_W-1:0]     csr_write_data
);

   dcfw_pkg::dcfw_cmd_type    ctrl_cmd;
   dcfw_pkg::dcfw_status_type ctrl_sts;

   dcfw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (ctrl_sts),
      .cmd       (ctrl_cmd)
   );

   dcfw_datapath #(
      .ROW_BYTES  (ROW_BYTES),
      .PIXEL_ROWS (PIXEL_ROWS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_command      (req_chan.command),
      .req_byte_value   (req_chan.byte_value),
      .req_read_address (req_chan.read_address),
      .rsp_read_data    (rsp_chan.read_data),
      .rsp_display_mode (rsp_chan.display_mode),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cmd              (ctrl_cmd),
      .sts              (ctrl_sts)
   );

   a_single_action: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctrl_cmd.clear_wr, ctrl_cmd.accept, ctrl_cmd.paint_rd,
                ctrl_cmd.paint_wr, ctrl_cmd.load_rsp}))
      else $error("more than one datapath action in a cycle");

   a_write_after_read: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.paint_wr |-> $past(ctrl_cmd.paint_rd))
      else $error("store write-back without a preceding read");

   a_short_request: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.accept && !ctrl_sts.paint_req && !rsp_chan.valid |=> ctrl_cmd.load_rsp)
      else $error("non-pixel request not answered in the following cycle");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.load_rsp |=> rsp_chan.valid)
      else $error("loaded response not presented");

endmodule

/* sv/dcfw_ctrl.sv */
module dcfw_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  dcfw_pkg::dcfw_status_type sts,
   output dcfw_pkg::dcfw_cmd_type   cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PAINT_RD,
      ST_PAINT_WR,
      ST_DONE
   } state_type;

   state_type                         state_ff, state_in;
   logic [dcfw_pkg::ROW_CNT_W-1:0]    row_ff, row_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      row_in = row_ff;
      cmd = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               row_in = '0;
               state_in = sts.paint_req ? ST_PAINT_RD : ST_DONE;
            end
         end
         ST_PAINT_RD: begin
            cmd.paint_rd = 1'b1;
            state_in = ST_PAINT_WR;
         end
         ST_PAINT_WR: begin
            cmd.paint_wr = 1'b1;
            row_in = row_ff + 1'b1;
            if (row_ff == dcfw_pkg::ROW_CNT_W'(dcfw_pkg::PAINT_ROWS - 1)) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_PAINT_RD;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               cmd.load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         row_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         row_ff <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

/* sv/dcfw_datapath.sv */
module dcfw_datapath #(
   parameter int unsigned ROW_BYTES = 16,
   parameter int unsigned PIXEL_ROWS = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [dcfw_pkg::CMD_W-1:0]      req_command,
   input  logic [dcfw_pkg::BYTE_W-1:0]     req_byte_value,
   input  logic [dcfw_pkg::RADDR_W-1:0]    req_read_address,
   output logic [dcfw_pkg::BYTE_W-1:0]     rsp_read_data,
   output logic [dcfw_pkg::BYTE_W-1:0]     rsp_display_mode,
   input  logic                            csr_write_enable,
   input  logic [dcfw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dcfw_pkg::BYTE_W-1:0]     csr_write_data,
   input  dcfw_pkg::dcfw_cmd_type          cmd,
   output dcfw_pkg::dcfw_status_type       sts
);

   localparam int unsigned DEPTH = ROW_BYTES * PIXEL_ROWS;
   localparam int unsigned ADDR_W = $clog2(DEPTH);
   localparam int unsigned PAINT_W = $clog2(32 + 263 * ROW_BYTES);

   logic [dcfw_pkg::BYTE_W-1:0] store [DEPTH];
   logic [dcfw_pkg::BYTE_W-1:0] mem_q_ff;

   logic [dcfw_pkg::BYTE_W-1:0] panel_width_ff, block_op_ff, mode_op_ff;
   logic [dcfw_pkg::BYTE_W-1:0] mode_ff, mode_in;
   logic [dcfw_pkg::BYTE_W-1:0] parse_ff, parse_in;
   logic [dcfw_pkg::BYTE_W-1:0] argc_ff, argc_in;
   logic [dcfw_pkg::BYTE_W-1:0] win_start_ff, win_start_in;
   logic [dcfw_pkg::BYTE_W-1:0] win_end_ff, win_end_in;
   logic [dcfw_pkg::BYTE_W-1:0] x_ff, x_in;
   logic [dcfw_pkg::BYTE_W-1:0] y_ff, y_in;
   logic [dcfw_pkg::BYTE_W-1:0] x_step, clamped, pc, ac;

   logic [PAINT_W-1:0]          paddr_ff;
   logic [dcfw_pkg::BYTE_W-1:0] pmask_ff, pbits_ff;
   logic                        rd_sel_ff;
   logic [ADDR_W-1:0]           clr_addr_ff;
   logic [dcfw_pkg::BYTE_W-1:0] rsp_data_ff, rsp_mode_ff;

   logic                        paint_in_range, read_in_range;
   logic [dcfw_pkg::BYTE_W-1:0] painted;

   assign sts.clear_last = (clr_addr_ff == ADDR_W'(DEPTH - 1));
   assign sts.paint_req = (req_command == dcfw_pkg::CMD_STREAM) &&
                          (parse_ff == dcfw_pkg::DATA_MODE);

   assign clamped = (req_byte_value >= panel_width_ff) ? panel_width_ff - 8'd1
                                                       : req_byte_value;
   assign x_step = x_ff + 8'd1;

   always_comb begin
      mode_in = mode_ff;
      parse_in = parse_ff;
      argc_in = argc_ff;
      win_start_in = win_start_ff;
      win_end_in = win_end_ff;
      x_in = x_ff;
      y_in = y_ff;
      pc = parse_ff;
      ac = argc_ff;
      if (cmd.accept) begin
         case (req_command)
            dcfw_pkg::CMD_STREAM: begin
               if (parse_ff == dcfw_pkg::AWAIT_MODE) begin
                  parse_in = req_byte_value;
               end else if (parse_ff == dcfw_pkg::DATA_MODE) begin
                  if (x_step > win_end_ff) begin
                     x_in = win_start_ff;
                     y_in = y_ff + 8'd8;
                  end else begin
                     x_in = x_step;
                  end
               end else begin
                  if (parse_ff == dcfw_pkg::COMMAND_MODE) begin
                     pc = req_byte_value;
                     ac = '0;
                  end
                  if (pc == block_op_ff) begin
                     if (ac == 8'd1) begin
                        win_start_in = clamped;
                        x_in = clamped;
                     end
                     if (ac == 8'd2) begin
                        win_end_in = clamped;
                     end
                     if (ac == 8'd3) begin
                        y_in = {req_byte_value[4:0], 3'b000};
                     end
                     if (ac == 8'd4) begin
                        pc = dcfw_pkg::COMMAND_MODE;
                     end
                  end
                  if ((pc == mode_op_ff) && (ac == 8'd1)) begin
                     mode_in = req_byte_value;
                     pc = dcfw_pkg::COMMAND_MODE;
                  end
                  parse_in = pc;
                  argc_in = ac + 8'd1;
               end
            end
            dcfw_pkg::CMD_START: begin
               parse_in = dcfw_pkg::AWAIT_MODE;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         panel_width_ff <= dcfw_pkg::RESET_PANEL_WIDTH;
         block_op_ff <= dcfw_pkg::RESET_BLOCK_OPCODE;
         mode_op_ff <= dcfw_pkg::RESET_MODE_OPCODE;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            dcfw_pkg::CSR_PANEL_WIDTH: panel_width_ff <= csr_write_data;
            dcfw_pkg::CSR_BLOCK_OPCODE: block_op_ff <= csr_write_data;
            dcfw_pkg::CSR_MODE_OPCODE: mode_op_ff <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= dcfw_pkg::RESET_DISPLAY_MODE;
         parse_ff <= dcfw_pkg::AWAIT_MODE;
         argc_ff <= '0;
         win_start_ff <= '0;
         win_end_ff <= '0;
         x_ff <= '0;
         y_ff <= '0;
         clr_addr_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         parse_ff <= parse_in;
         argc_ff <= argc_in;
         win_start_ff <= win_start_in;
         win_end_ff <= win_end_in;
         x_ff <= x_in;
         y_ff <= y_in;
         if (cmd.clear_wr) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         paddr_ff <= PAINT_W'(x_ff[7:3]) + PAINT_W'(y_ff) * PAINT_W'(ROW_BYTES);
         pmask_ff <= 8'd1 << x_ff[2:0];
         pbits_ff <= req_byte_value;
         rd_sel_ff <= (req_command == dcfw_pkg::CMD_READ) && read_in_range;
      end else if (cmd.paint_wr) begin
         paddr_ff <= paddr_ff + PAINT_W'(ROW_BYTES);
         pbits_ff <= pbits_ff >> 1;
      end
      if (cmd.load_rsp) begin
         rsp_data_ff <= rd_sel_ff ? mem_q_ff : '0;
         rsp_mode_ff <= mode_ff;
      end
   end

   assign paint_in_range = (paddr_ff < PAINT_W'(DEPTH));
   assign read_in_range = (32'(req_read_address) < 32'(DEPTH));
   assign painted = pbits_ff[0] ? (mem_q_ff | pmask_ff) : (mem_q_ff & ~pmask_ff);

   always_ff @(posedge clock) begin
      if (cmd.clear_wr) begin
         store[clr_addr_ff] <= '0;
      end else if (cmd.paint_wr && paint_in_range) begin
         store[ADDR_W'(paddr_ff)] <= painted;
      end
      if (cmd.accept) begin
         mem_q_ff <= store[ADDR_W'(req_read_address)];
      end else if (cmd.paint_rd) begin
         mem_q_ff <= store[ADDR_W'(paddr_ff)];
      end
   end

   assign rsp_read_data = rsp_data_ff;
   assign rsp_display_mode = rsp_mode_ff;

endmodule
